// ----- rtl/sbb_pkg.sv -----
// Shared types, widths, codes and the saturation helper for the shape bounding box block.
// Used by every module of the block; depends on nothing.

package sbb_pkg;

	localparam int COORD_W       = 32;
	localparam int ROT_W         = 16;
	localparam int DIST_W        = 31;
	localparam int KIND_W        = 3;
	localparam int ROT_FRAC_BITS = 14;

	localparam int PROD_W = COORD_W + ROT_W;
	localparam int RSUM_W = PROD_W + 1;
	localparam int RSH_W  = RSUM_W - ROT_FRAC_BITS;
	localparam int SAT_W  = RSH_W + 1;
	localparam int GROW_W = DIST_W + 1;

	localparam int MID_DEPTH = 4;
	localparam int MID_PTR_W = $clog2(MID_DEPTH);
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_SPEC_DIST   = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_AABB_MARGIN = 1'd1;

	localparam logic [DIST_W-1:0] SPEC_DIST_RESET   = 31'd262144;
	localparam logic [DIST_W-1:0] AABB_MARGIN_RESET = 31'd6554;

	localparam logic [KIND_W-1:0] KIND_CAPSULE       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CIRCLE        = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POLYGON       = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SEGMENT       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CHAIN_SEGMENT = 3'd4;

	localparam logic signed [RSUM_W-1:0] ROT_HALF = RSUM_W'(1) <<< (ROT_FRAC_BITS - 1);
	localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [ROT_W-1:0]   rot_cos;
		logic signed [ROT_W-1:0]   rot_sin;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [DIST_W-1:0]         shape_radius;
		logic [KIND_W-1:0]         shape_kind;
		logic                      is_static;
		logic                      last_point;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] box_min_x;
		logic signed [COORD_W-1:0] box_min_y;
		logic signed [COORD_W-1:0] box_max_x;
		logic signed [COORD_W-1:0] box_max_y;
		logic signed [COORD_W-1:0] fat_min_x;
		logic signed [COORD_W-1:0] fat_min_y;
		logic signed [COORD_W-1:0] fat_max_x;
		logic signed [COORD_W-1:0] fat_max_y;
		logic                      clipped;
	} result_t;

	// One finished shape, handed from the point pipeline to the box unit.
	typedef struct packed {
		logic signed [COORD_W-1:0] lo_x;
		logic signed [COORD_W-1:0] lo_y;
		logic signed [COORD_W-1:0] hi_x;
		logic signed [COORD_W-1:0] hi_y;
		logic                      clip;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic [DIST_W-1:0]         shape_radius;
		logic [KIND_W-1:0]         shape_kind;
		logic                      is_static;
	} shape_rec_t;

	typedef struct packed {
		logic                      clip;
		logic signed [COORD_W-1:0] value;
	} sat_t;

	function automatic sat_t sat_coord(input logic signed [SAT_W-1:0] v);
		sat_t r;
		if (!v[SAT_W-1] && (|v[SAT_W-2:COORD_W-1])) begin
			r.clip  = 1'b1;
			r.value = COORD_MAX;
		end else if (v[SAT_W-1] && !(&v[SAT_W-2:COORD_W-1])) begin
			r.clip  = 1'b1;
			r.value = COORD_MIN;
		end else begin
			r.clip  = 1'b0;
			r.value = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/sbb_front.sv -----
// Point pipeline: rotates and translates each point and keeps the running box.
// Depends on sbb_pkg; hands one record per finished shape to the middle queue.

module sbb_front
	import sbb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  item_t      item,
	output logic       rec_push,
	output shape_rec_t rec,
	input  logic       rec_full
);

	logic adv;

	logic  v_s1;
	item_t item_s1;

	logic                      v_s2;
	logic signed [PROD_W-1:0]  cpx_s2, spy_s2, spx_s2, cpy_s2;
	item_t                     meta_s2;

	logic                      v_s3;
	logic signed [RSH_W-1:0]   rx_s3, ry_s3;
	item_t                     meta_s3;

	logic                      v_s4;
	logic signed [COORD_W-1:0] wx_s4, wy_s4;
	logic                      clip_s4;
	item_t                     meta_s4;

	logic signed [RSUM_W-1:0]  rsum_x, rsum_y;
	logic signed [SAT_W-1:0]   tsum_x, tsum_y;
	sat_t                      sat_x, sat_y;

	logic signed [COORD_W-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
	logic                      awaiting_q, run_clip_q;
	logic signed [COORD_W-1:0] nmin_x, nmin_y, nmax_x, nmax_y;
	logic                      nclip;

	assign adv  = !(v_s4 && meta_s4.last_point && rec_full);
	assign full = !adv;

	assign rsum_x = RSUM_W'(cpx_s2) - RSUM_W'(spy_s2) + ROT_HALF;
	assign rsum_y = RSUM_W'(spx_s2) + RSUM_W'(cpy_s2) + ROT_HALF;
	assign tsum_x = SAT_W'(rx_s3) + SAT_W'(meta_s3.pos_x);
	assign tsum_y = SAT_W'(ry_s3) + SAT_W'(meta_s3.pos_y);
	assign sat_x  = sat_coord(tsum_x);
	assign sat_y  = sat_coord(tsum_y);

	assign nmin_x = (awaiting_q || wx_s4 < min_x_q) ? wx_s4 : min_x_q;
	assign nmax_x = (awaiting_q || wx_s4 > max_x_q) ? wx_s4 : max_x_q;
	assign nmin_y = (awaiting_q || wy_s4 < min_y_q) ? wy_s4 : min_y_q;
	assign nmax_y = (awaiting_q || wy_s4 > max_y_q) ? wy_s4 : max_y_q;
	assign nclip  = run_clip_q || clip_s4;

	assign rec_push          = adv && v_s4 && meta_s4.last_point;
	assign rec.lo_x          = nmin_x;
	assign rec.lo_y          = nmin_y;
	assign rec.hi_x          = nmax_x;
	assign rec.hi_y          = nmax_y;
	assign rec.clip          = nclip;
	assign rec.pos_x         = meta_s4.pos_x;
	assign rec.pos_y         = meta_s4.pos_y;
	assign rec.shape_radius  = meta_s4.shape_radius;
	assign rec.shape_kind    = meta_s4.shape_kind;
	assign rec.is_static     = meta_s4.is_static;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			awaiting_q <= 1'b1;
			run_clip_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4) begin
				awaiting_q <= meta_s4.last_point;
				run_clip_q <= nclip && !meta_s4.last_point;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item;
			cpx_s2  <= PROD_W'(item_s1.rot_cos) * PROD_W'(item_s1.point_x);
			spy_s2  <= PROD_W'(item_s1.rot_sin) * PROD_W'(item_s1.point_y);
			spx_s2  <= PROD_W'(item_s1.rot_sin) * PROD_W'(item_s1.point_x);
			cpy_s2  <= PROD_W'(item_s1.rot_cos) * PROD_W'(item_s1.point_y);
			meta_s2 <= item_s1;
			rx_s3   <= RSH_W'(rsum_x >>> ROT_FRAC_BITS);
			ry_s3   <= RSH_W'(rsum_y >>> ROT_FRAC_BITS);
			meta_s3 <= meta_s2;
			wx_s4   <= sat_x.value;
			wy_s4   <= sat_y.value;
			clip_s4 <= sat_x.clip || sat_y.clip;
			meta_s4 <= meta_s3;
			if (v_s4) begin
				min_x_q <= nmin_x;
				min_y_q <= nmin_y;
				max_x_q <= nmax_x;
				max_y_q <= nmax_y;
			end
		end
	end

endmodule

// ----- rtl/sbb_queue.sv -----
// Short queue of finished shape records between the point pipeline and the box unit.
// Depends on sbb_pkg for the record type and depth.

module sbb_queue
	import sbb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  shape_rec_t rec_in,
	output logic       full,
	input  logic       pop,
	output shape_rec_t rec_out,
	output logic       empty
);

	shape_rec_t           mem_q [MID_DEPTH];
	logic [MID_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [MID_PTR_W:0]   count_q;
	logic                 do_push, do_pop;

	assign full    = (count_q == (MID_PTR_W + 1)'(MID_DEPTH));
	assign empty   = (count_q == '0);
	assign rec_out = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= rec_in;
		end
	end

endmodule

// ----- rtl/sbb_back.sv -----
// Box unit: grows each box by speculative distance, kind radius if any, and margin.
// Depends on sbb_pkg; ends in the result queue that the top level exposes.

module sbb_back
	import sbb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rec_empty,
	output logic              rec_pop,
	input  shape_rec_t        rec,
	input  logic [DIST_W-1:0] spec_dist,
	input  logic [DIST_W-1:0] aabb_margin,
	output logic              empty,
	input  logic              pop,
	output result_t           result
);

	logic [OUT_PTR_W:0] reserve_q;
	logic               take;

	logic                      known;
	logic [DIST_W-1:0]         radius_sel;

	logic                      v_s1;
	logic signed [COORD_W-1:0] lo_x_s1, lo_y_s1, hi_x_s1, hi_y_s1;
	logic [GROW_W-1:0]         grow_s1;
	logic [DIST_W-1:0]         margin_s1;
	logic                      clip_s1;

	sat_t                      b_lx, b_ly, b_hx, b_hy;

	logic                      v_s2;
	logic signed [COORD_W-1:0] bx_lo_s2, by_lo_s2, bx_hi_s2, by_hi_s2;
	logic [DIST_W-1:0]         margin_s2;
	logic                      clip_s2;

	sat_t                      f_lx, f_ly, f_hx, f_hy;
	result_t                   res_new;

	result_t              mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUT_PTR_W:0]   count_q;
	logic                 do_pop;

	assign take    = !rec_empty && (reserve_q != (OUT_PTR_W + 1)'(OUT_DEPTH));
	assign rec_pop = take;

	always_comb begin
		unique case (rec.shape_kind) inside
			KIND_CAPSULE, KIND_CIRCLE, KIND_POLYGON: begin
				known      = 1'b1;
				radius_sel = rec.shape_radius;
			end
			KIND_SEGMENT, KIND_CHAIN_SEGMENT: begin
				known      = 1'b1;
				radius_sel = '0;
			end
			default: begin
				known      = 1'b0;
				radius_sel = '0;
			end
		endcase
	end

	assign b_lx = sat_coord(SAT_W'(lo_x_s1) - SAT_W'(grow_s1));
	assign b_ly = sat_coord(SAT_W'(lo_y_s1) - SAT_W'(grow_s1));
	assign b_hx = sat_coord(SAT_W'(hi_x_s1) + SAT_W'(grow_s1));
	assign b_hy = sat_coord(SAT_W'(hi_y_s1) + SAT_W'(grow_s1));

	assign f_lx = sat_coord(SAT_W'(bx_lo_s2) - SAT_W'(margin_s2));
	assign f_ly = sat_coord(SAT_W'(by_lo_s2) - SAT_W'(margin_s2));
	assign f_hx = sat_coord(SAT_W'(bx_hi_s2) + SAT_W'(margin_s2));
	assign f_hy = sat_coord(SAT_W'(by_hi_s2) + SAT_W'(margin_s2));

	assign res_new.box_min_x = bx_lo_s2;
	assign res_new.box_min_y = by_lo_s2;
	assign res_new.box_max_x = bx_hi_s2;
	assign res_new.box_max_y = by_hi_s2;
	assign res_new.fat_min_x = f_lx.value;
	assign res_new.fat_min_y = f_ly.value;
	assign res_new.fat_max_x = f_hx.value;
	assign res_new.fat_max_y = f_hy.value;
	assign res_new.clipped   = clip_s2 || f_lx.clip || f_ly.clip || f_hx.clip || f_hy.clip;

	assign empty  = (count_q == '0);
	assign result = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			reserve_q <= '0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			count_q   <= '0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			if (take && !do_pop) begin
				reserve_q <= reserve_q + 1'b1;
			end else if (do_pop && !take) begin
				reserve_q <= reserve_q - 1'b1;
			end
			if (v_s2) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (v_s2 && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !v_s2) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lo_x_s1   <= known ? rec.lo_x : rec.pos_x;
			lo_y_s1   <= known ? rec.lo_y : rec.pos_y;
			hi_x_s1   <= known ? rec.hi_x : rec.pos_x;
			hi_y_s1   <= known ? rec.hi_y : rec.pos_y;
			grow_s1   <= GROW_W'(radius_sel) + GROW_W'(spec_dist);
			margin_s1 <= rec.is_static ? spec_dist : aabb_margin;
			clip_s1   <= known && rec.clip;
		end
		bx_lo_s2  <= b_lx.value;
		by_lo_s2  <= b_ly.value;
		bx_hi_s2  <= b_hx.value;
		by_hi_s2  <= b_hy.value;
		margin_s2 <= margin_s1;
		clip_s2   <= clip_s1 || b_lx.clip || b_ly.clip || b_hx.clip || b_hy.clip;
		if (v_s2) begin
			mem_q[wr_ptr_q] <= res_new;
		end
	end

endmodule

// ----- rtl/shape_bounding_box_update.sv -----
// Top level of the shape bounding box block: configuration registers and the three parts.
// Depends on sbb_pkg, sbb_front, sbb_queue and sbb_back.

// The block takes one shape point per cycle while full is low and gives one result per
// shape, on the point marked last. A point passes the transform pipeline (operand
// register, multipliers, rounding shift, translation with saturation) before it updates
// the running box; a finished shape then waits in a four-entry queue and passes the
// input and grown-box registers of the box unit before it lands in a four-entry result
// queue. full rises only when four finished shapes wait in the middle queue and a fifth
// reaches the end of the transform pipeline; the box unit takes a shape only while the
// result queue has room reserved for it. There is no clearing pass after reset.

module shape_bounding_box_update
	import sbb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  item_t                item,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [DIST_W-1:0]    wr_data,
	output logic                 empty,
	input  logic                 pop,
	output result_t              result
);

	logic [DIST_W-1:0] spec_dist_q, aabb_margin_q;

	logic       rec_push, rec_full, rec_empty, rec_pop;
	shape_rec_t rec_in, rec_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spec_dist_q   <= SPEC_DIST_RESET;
			aabb_margin_q <= AABB_MARGIN_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SPEC_DIST:   spec_dist_q   <= wr_data;
				REG_AABB_MARGIN: aabb_margin_q <= wr_data;
				default: ;
			endcase
		end
	end

	sbb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.rec_push (rec_push),
		.rec      (rec_in),
		.rec_full (rec_full)
	);

	sbb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (rec_push),
		.rec_in  (rec_in),
		.full    (rec_full),
		.pop     (rec_pop),
		.rec_out (rec_out),
		.empty   (rec_empty)
	);

	sbb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec_empty   (rec_empty),
		.rec_pop     (rec_pop),
		.rec         (rec_out),
		.spec_dist   (spec_dist_q),
		.aabb_margin (aabb_margin_q),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule

// ----- rtl/sbb_checker.sv -----
// Port-level checks for the shape bounding box block, bound to its top level.
// Depends on sbb_pkg for the item and result types.

module sbb_checker
	import sbb_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    push,
	input logic    full,
	input item_t   item,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	logic [4:0] pend_q;
	logic       last_in, res_out;

	assign last_in = push && !full && item.last_point;
	assign res_out = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (last_in && !res_out) begin
			pend_q <= pend_q + 1'b1;
		end else if (res_out && !last_in) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_empty_in_reset: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("Result queue not empty after reset.");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("Waiting result changed before it was taken.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pend_q != '0))
		else $error("Result shown without a pending last item.");

	a_fat_contains: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.fat_min_x <= result.box_min_x && result.fat_min_y <= result.box_min_y
			&& result.fat_max_x >= result.box_max_x && result.fat_max_y >= result.box_max_y
			&& result.box_min_x <= result.box_max_x && result.box_min_y <= result.box_max_y))
		else $error("Fat box does not contain an ordered tight box.");

endmodule

bind shape_bounding_box_update sbb_checker u_sbb_checker (.*);

// ----- bench/shape_bounding_box_update_test.sv -----
// Testbench for shape_bounding_box_update: sends shape points through the push/full side and
// checks every box on the empty/pop side against a fixed-point box predictor kept here.
// Depends on sbb_pkg and the shape_bounding_box_update RTL.
`timescale 1ns / 100ps

module shape_bounding_box_update_test;
	import sbb_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	item_t                point_in = '0;
	logic                 wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [DIST_W-1:0]    wr_data = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	result_t              box_out;

	shape_bounding_box_update DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(point_in),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.empty(empty),
		.pop(pop),
		.result(box_out)
	);

	localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fffffff;
	localparam logic signed [COORD_W-1:0] C_MIN = 32'sh80000000;
	localparam logic [DIST_W-1:0] DIST_MAX = 31'h7fffffff;
	localparam logic signed [ROT_W-1:0] ROT_ONE = 16'sd16384;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN     = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN_TOP = 3'd7;

	// Predictor state and its copy of the configuration.
	logic signed [COORD_W-1:0] span_min_x = '0, span_min_y = '0;
	logic signed [COORD_W-1:0] span_max_x = '0, span_max_y = '0;
	bit                        shape_fresh = 1'b1;
	bit                        shape_clip = 1'b0;
	logic [DIST_W-1:0]         spec_dist = SPEC_DIST_RESET;
	logic [DIST_W-1:0]         fat_margin = AABB_MARGIN_RESET;

	result_t boxes_due[$];
	int      errors = 0;
	int      items_sent = 0;
	int      pop_stall = 0;
	bit      no_idle = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [COORD_W-1:0] clamp(input longint v, inout bit clip);
		if (v > longint'(C_MAX)) begin
			clip = 1'b1;
			return C_MAX;
		end
		if (v < longint'(C_MIN)) begin
			clip = 1'b1;
			return C_MIN;
		end
		return v[COORD_W-1:0];
	endfunction

	// Rotates and translates one point, folds it into the running box and,
	// on the last point of a shape, works out the box that the block must give.
	function automatic bit track_point(input item_t it, output result_t r);
		bit clip;
		longint c, s, px, py, tx, ty, half;
		longint lo_x, lo_y, hi_x, hi_y, grow, fat;
		logic signed [COORD_W-1:0] wx, wy;
		r = '0;
		clip = 1'b0;
		c = longint'(it.rot_cos);
		s = longint'(it.rot_sin);
		px = longint'(it.point_x);
		py = longint'(it.point_y);
		tx = longint'(it.pos_x);
		ty = longint'(it.pos_y);
		half = longint'(ROT_HALF);
		wx = clamp(((c * px - s * py + half) >>> ROT_FRAC_BITS) + tx, clip);
		wy = clamp(((s * px + c * py + half) >>> ROT_FRAC_BITS) + ty, clip);
		if (clip)
			shape_clip = 1'b1;
		if (shape_fresh) begin
			span_min_x = wx;
			span_max_x = wx;
			span_min_y = wy;
			span_max_y = wy;
			shape_fresh = 1'b0;
		end else begin
			if (wx < span_min_x) span_min_x = wx;
			if (wx > span_max_x) span_max_x = wx;
			if (wy < span_min_y) span_min_y = wy;
			if (wy > span_max_y) span_max_y = wy;
		end
		if (!it.last_point)
			return 1'b0;

		clip = 1'b0;
		if (it.shape_kind <= KIND_CHAIN_SEGMENT) begin
			clip = shape_clip;
			lo_x = longint'(span_min_x);
			lo_y = longint'(span_min_y);
			hi_x = longint'(span_max_x);
			hi_y = longint'(span_max_y);
			grow = (it.shape_kind <= KIND_POLYGON) ? longint'(it.shape_radius) : longint'(0);
		end else begin
			lo_x = tx;
			hi_x = tx;
			lo_y = ty;
			hi_y = ty;
			grow = 0;
		end
		grow += longint'(spec_dist);
		r.box_min_x = clamp(lo_x - grow, clip);
		r.box_min_y = clamp(lo_y - grow, clip);
		r.box_max_x = clamp(hi_x + grow, clip);
		r.box_max_y = clamp(hi_y + grow, clip);
		fat = it.is_static ? longint'(spec_dist) : longint'(fat_margin);
		r.fat_min_x = clamp(longint'(r.box_min_x) - fat, clip);
		r.fat_min_y = clamp(longint'(r.box_min_y) - fat, clip);
		r.fat_max_x = clamp(longint'(r.box_max_x) + fat, clip);
		r.fat_max_y = clamp(longint'(r.box_max_y) + fat, clip);
		r.clipped = clip;
		shape_fresh = 1'b1;
		shape_clip = 1'b0;
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord(input int scale);
		case (scale)
			0: return int'($urandom_range(0, 131072)) - 65536;
			1: return int'($urandom_range(0, 33554432)) - 16777216;
			2: return $urandom;
			default: begin
				case ($urandom_range(0, 4))
					0: return C_MAX;
					1: return C_MIN;
					2: return '0;
					3: return '1;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	function automatic logic signed [ROT_W-1:0] rand_rot();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 2))
					0: return ROT_ONE;
					1: return -ROT_ONE;
					default: return '0;
				endcase
			end
			1: return ROT_W'($urandom);
			default: return ROT_W'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic logic [DIST_W-1:0] rand_dist();
		case ($urandom_range(0, 9))
			0: return DIST_MAX;
			1: return '0;
			2: return DIST_W'($urandom);
			default: return DIST_W'($urandom_range(0, 1048576));
		endcase
	endfunction

	function automatic item_t make_point(
		input logic signed [COORD_W-1:0] px, py, tx, ty,
		input logic signed [ROT_W-1:0] c, s,
		input logic [DIST_W-1:0] radius,
		input logic [KIND_W-1:0] kind,
		input bit is_static, last);
		item_t it;
		it.pos_x = tx;
		it.pos_y = ty;
		it.rot_cos = c;
		it.rot_sin = s;
		it.point_x = px;
		it.point_y = py;
		it.shape_radius = radius;
		it.shape_kind = kind;
		it.is_static = is_static;
		it.last_point = last;
		return it;
	endfunction

	task automatic send_point(input item_t it);
		int gap;
		result_t r;
		gap = pick_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		point_in <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
		if (track_point(it, r))
			boxes_due.push_back(r);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIST_W-1:0] value);
		push <= 1'b0;
		while (boxes_due.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_SPEC_DIST)
			spec_dist = value;
		else
			fat_margin = value;
	endtask

	task automatic check_field(input string name, input logic [COORD_W-1:0] want, got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, $signed(want), $signed(got));
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (boxes_due.size() == 0) begin
					$display("%0t: unexpected box, expected none, got %p", $time, box_out);
					errors++;
				end else begin
					result_t want;
					want = boxes_due.pop_front();
					check_field("box_min_x", want.box_min_x, box_out.box_min_x);
					check_field("box_min_y", want.box_min_y, box_out.box_min_y);
					check_field("box_max_x", want.box_max_x, box_out.box_max_x);
					check_field("box_max_y", want.box_max_y, box_out.box_max_y);
					check_field("fat_min_x", want.fat_min_x, box_out.fat_min_x);
					check_field("fat_min_y", want.fat_min_y, box_out.fat_min_y);
					check_field("fat_max_x", want.fat_max_x, box_out.fat_max_x);
					check_field("fat_max_y", want.fat_max_y, box_out.fat_max_y);
					check_field("clipped", 32'(want.clipped), 32'(box_out.clipped));
				end
				pop_stall = pick_gap();
			end
			if (pop_stall > 0) begin
				pop <= 1'b0;
				pop_stall--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic test_each_kind();
		for (int k = 0; k < 8; k++)
			send_point(make_point(rand_coord(0), rand_coord(0), rand_coord(1), rand_coord(1),
				rand_rot(), rand_rot(), rand_dist(), KIND_W'(k), k[0], 1'b1));
	endtask

	task automatic test_multi_point();
		// Kind and radius on the points before the last must have no effect.
		send_point(make_point(32'sd65536, 32'sd0, 32'sd655360, -32'sd131072,
			16'sd11585, 16'sd11585, DIST_MAX, KIND_UNKNOWN, 1'b1, 1'b0));
		send_point(make_point(-32'sd98304, 32'sd40000, 32'sd655360, -32'sd131072,
			16'sd11585, 16'sd11585, DIST_MAX, KIND_UNKNOWN_TOP, 1'b1, 1'b0));
		send_point(make_point(32'sd12345, -32'sd200000, 32'sd655360, -32'sd131072,
			16'sd11585, 16'sd11585, 31'd32768, KIND_POLYGON, 1'b1, 1'b1));
		send_point(make_point(-32'sd300000, 32'sd5, -32'sd7, 32'sd9,
			ROT_ONE, 16'sd0, 31'd0, KIND_CAPSULE, 1'b0, 1'b0));
		send_point(make_point(32'sd300000, -32'sd5, -32'sd7, 32'sd9,
			ROT_ONE, 16'sd0, DIST_MAX, KIND_SEGMENT, 1'b0, 1'b1));
	endtask

	task automatic test_saturation();
		send_point(make_point(C_MAX, C_MIN, C_MAX, C_MAX, ROT_ONE, ROT_ONE,
			DIST_MAX, KIND_CIRCLE, 1'b0, 1'b1));
		send_point(make_point(C_MIN, C_MAX, C_MIN, C_MIN, ROT_ONE, -ROT_ONE,
			DIST_MAX, KIND_CAPSULE, 1'b1, 1'b1));
		// A saturated point is dropped when the shape turns out to be of unknown kind.
		send_point(make_point(C_MAX, 32'sd0, C_MAX, 32'sd0, ROT_ONE, 16'sd0,
			31'd0, KIND_CIRCLE, 1'b0, 1'b0));
		send_point(make_point(32'sd0, 32'sd0, 32'sd6553600, -32'sd6553600, ROT_ONE, 16'sd0,
			DIST_MAX, KIND_UNKNOWN, 1'b0, 1'b1));
	endtask

	task automatic test_rounding();
		send_point(make_point(32'sd1, 32'sd0, 32'sd0, 32'sd0, 16'sd8192, 16'sd0,
			31'd0, KIND_SEGMENT, 1'b0, 1'b1));
		send_point(make_point(-32'sd1, 32'sd0, 32'sd0, 32'sd0, 16'sd8192, 16'sd0,
			31'd0, KIND_CHAIN_SEGMENT, 1'b1, 1'b1));
	endtask

	task automatic test_unnormalized_rotation();
		send_point(make_point(rand_coord(1), rand_coord(1), rand_coord(0), rand_coord(0),
			16'sh8000, 16'sh7fff, rand_dist(), KIND_CIRCLE, 1'b0, 1'b1));
		send_point(make_point(rand_coord(2), rand_coord(2), rand_coord(1), rand_coord(1),
			16'sh7fff, 16'sh8000, rand_dist(), KIND_POLYGON, 1'b1, 1'b1));
	endtask

	task automatic send_shape();
		item_t base, it;
		int n, k, scale, r;
		r = $urandom_range(0, 9);
		scale = (r < 5) ? 0 : (r < 8) ? 1 : (r == 8) ? 2 : 3;
		base = make_point('0, '0, rand_coord(scale), rand_coord(scale), rand_rot(), rand_rot(),
			'0, '0, 1'($urandom_range(0, 1)), 1'b0);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
		k = $urandom_range(0, 19);
		for (int i = 0; i < n; i++) begin
			it = base;
			if ($urandom_range(0, 19) == 0) begin
				it.pos_x = rand_coord(scale);
				it.rot_sin = rand_rot();
				it.is_static = ~it.is_static;
			end
			it.point_x = rand_coord(scale);
			it.point_y = rand_coord(scale);
			it.shape_radius = rand_dist();
			it.shape_kind = KIND_W'($urandom_range(0, 7));
			it.last_point = (i == n - 1);
			if (it.last_point)
				it.shape_kind = (k < 17) ? KIND_W'(k % 5) : KIND_W'(k - 12);
			send_point(it);
		end
	endtask

	task automatic test_random_sweep();
		logic [DIST_W-1:0] spec_set[6];
		logic [DIST_W-1:0] margin_set[6];
		spec_set = '{SPEC_DIST_RESET, '0, DIST_MAX, '0, DIST_MAX, '0};
		margin_set = '{AABB_MARGIN_RESET, '0, '0, DIST_MAX, DIST_MAX, '0};
		spec_set[5] = rand_dist();
		margin_set[5] = rand_dist();
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_SPEC_DIST, spec_set[p]);
			write_reg(REG_AABB_MARGIN, margin_set[p]);
			while (items_sent < 21 + 275 * (p + 1)) begin
				if ($urandom_range(0, 29) == 0)
					no_idle = !no_idle;
				send_shape();
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_each_kind();
		test_multi_point();
		test_saturation();
		test_rounding();
		test_unnormalized_rotation();
		test_random_sweep();
		push <= 1'b0;
		while (boxes_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/sbb_pkg.sv
rtl/sbb_front.sv
rtl/sbb_queue.sv
rtl/sbb_back.sv
rtl/shape_bounding_box_update.sv
rtl/sbb_checker.sv
bench/shape_bounding_box_update_test.sv
